/* rtl/core/sxt_pkg.sv */
package sxt_pkg;

    localparam int NUM_SAMPLES   = 6;
    localparam int NUM_CHANNELS  = 3;
    localparam int CH_W          = 8;
    localparam int COLOR_W       = NUM_CHANNELS * CH_W;
    localparam int THR_W         = 17;
    localparam int GLYPH_W       = 17;
    localparam int LUMA_BITS_DEF = 16;

    // channel sum of up to six bytes, and sample count 0..6
    localparam int SUM_W         = 11;
    localparam int CNT_W         = 3;

    // reciprocal scaled by 2^16, exact for every sum below 2^16 / 5
    localparam int RECIP_SHIFT   = 16;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int PROD_W        = SUM_W + RECIP_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

    localparam logic [NUM_SAMPLES-1:0] MASK_EMPTY = 6'd0;
    localparam logic [NUM_SAMPLES-1:0] MASK_LEFT  = 6'd21;
    localparam logic [NUM_SAMPLES-1:0] MASK_RIGHT = 6'd42;
    localparam logic [NUM_SAMPLES-1:0] MASK_FULL  = 6'd63;

    localparam logic [GLYPH_W-1:0] CP_SPACE      = 17'h00020;
    localparam logic [GLYPH_W-1:0] CP_LEFT_HALF  = 17'h0258C;
    localparam logic [GLYPH_W-1:0] CP_RIGHT_HALF = 17'h02590;
    localparam logic [GLYPH_W-1:0] CP_FULL       = 17'h02588;
    localparam logic [GLYPH_W-1:0] SEXTANT_BASE  = 17'h1FB00;

    // per-stage load enables handed to the averaging lanes
    typedef struct packed {
        logic mul_en;
        logic out_en;
    } sxt_adv_t;

    typedef logic [NUM_CHANNELS-1:0][SUM_W-1:0] sxt_sums_t;

    function automatic logic [GLYPH_W-1:0] glyph_for(input logic [NUM_SAMPLES-1:0] m);
        logic [GLYPH_W-1:0] skip;
        logic [GLYPH_W-1:0] code;
        skip = '0;
        if (m > MASK_LEFT) begin
            skip = skip + GLYPH_W'(1);
        end
        if (m > MASK_RIGHT) begin
            skip = skip + GLYPH_W'(1);
        end
        unique case (m)
            MASK_EMPTY: code = CP_SPACE;
            MASK_LEFT:  code = CP_LEFT_HALF;
            MASK_RIGHT: code = CP_RIGHT_HALF;
            MASK_FULL:  code = CP_FULL;
            default:    code = SEXTANT_BASE + GLYPH_W'(m) - GLYPH_W'(1) - skip;
        endcase
        return code;
    endfunction

    // ceil(2^16 / n); an empty group maps to zero so the average comes out black
    function automatic logic [RECIP_W-1:0] recip_for(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            3'd6:    r = 17'd10923;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/sxt_group_avg.sv */
module sxt_group_avg
    import sxt_pkg::*;
(
    input  logic               aclk,
    input  sxt_adv_t           adv,
    input  sxt_sums_t          sums,
    input  logic [CNT_W-1:0]   count,
    output logic [COLOR_W-1:0] color
);

    logic [NUM_CHANNELS-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_CHANNELS-1:0][PROD_W-1:0] prod_next;
    logic [COLOR_W-1:0]                  color_reg;
    logic [COLOR_W-1:0]                  color_next;
    logic [RECIP_W-1:0]                  recip;

    // multiply by reciprocal
    always_comb begin
        recip = recip_for(count);
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            prod_next[c] = PROD_W'(sums[c]) * PROD_W'(recip);
        end
    end

    // scale back and pack
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            color_next[c*CH_W +: CH_W] = prod_reg[c][RECIP_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.mul_en) begin
            prod_reg <= prod_next;
        end
        if (adv.out_en) begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

/* rtl/core/sextant_cell_encoder.sv */
// Sextant cell encoder: turns one text cell of six samples (two wide, three
// tall) into a block-character code point, the lit mask and the average
// foreground and background colours. A sample is lit when its luminance is at
// or above cfg lit threshold (reset one half). Four register stages: mask
// compare, group sums and glyph lookup, reciprocal multiply, output. A new
// cell is taken every cycle while the result side keeps up, and each stage
// holds its item independently so a stall on m_ready fills the bubbles
// before s_ready drops.
// The threshold should be written only while the pipeline is empty.
module sextant_cell_encoder
    import sxt_pkg::*;
#(
    parameter int LUMA_BITS = LUMA_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [THR_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COLOR_W-1:0]   s_color_0,
    input  logic [COLOR_W-1:0]   s_color_1,
    input  logic [COLOR_W-1:0]   s_color_2,
    input  logic [COLOR_W-1:0]   s_color_3,
    input  logic [COLOR_W-1:0]   s_color_4,
    input  logic [COLOR_W-1:0]   s_color_5,
    input  logic [LUMA_BITS-1:0] s_luma_0,
    input  logic [LUMA_BITS-1:0] s_luma_1,
    input  logic [LUMA_BITS-1:0] s_luma_2,
    input  logic [LUMA_BITS-1:0] s_luma_3,
    input  logic [LUMA_BITS-1:0] s_luma_4,
    input  logic [LUMA_BITS-1:0] s_luma_5,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [GLYPH_W-1:0]   m_glyph_code,
    output logic [NUM_SAMPLES-1:0] m_lit_mask,
    output logic [COLOR_W-1:0]   m_fg_color,
    output logic [COLOR_W-1:0]   m_bg_color
);

    // compare width covers both the luminance and the 17-bit threshold
    localparam int CMP_W = (LUMA_BITS > THR_W) ? LUMA_BITS : THR_W;

    // threshold register
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // stage valids and load enables; a stage loads when empty or when it drains
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    sxt_adv_t adv;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign adv.mul_en = en3;
    assign adv.out_en = en4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: threshold compare per sample
    logic [NUM_SAMPLES-1:0][COLOR_W-1:0]   col_in;
    logic [NUM_SAMPLES-1:0][LUMA_BITS-1:0] luma_in;
    logic [NUM_SAMPLES-1:0]                mask1_next;
    logic [NUM_SAMPLES-1:0]                mask1_reg;
    logic [NUM_SAMPLES-1:0][COLOR_W-1:0]   col1_reg;

    assign col_in  = {s_color_5, s_color_4, s_color_3, s_color_2, s_color_1, s_color_0};
    assign luma_in = {s_luma_5, s_luma_4, s_luma_3, s_luma_2, s_luma_1, s_luma_0};

    always_comb begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            mask1_next[i] = CMP_W'(luma_in[i]) >= CMP_W'(thr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mask1_reg <= mask1_next;
            col1_reg  <= col_in;
        end
    end

    // stage 2: per-channel sums of the lit and unlit groups, counts, glyph
    sxt_sums_t            lit_sum_next, unl_sum_next;
    sxt_sums_t            lit_sum_reg, unl_sum_reg;
    logic [CNT_W-1:0]     lit_cnt_next, unl_cnt_next;
    logic [CNT_W-1:0]     lit_cnt_reg, unl_cnt_reg;
    logic [GLYPH_W-1:0]   glyph2_reg;
    logic [NUM_SAMPLES-1:0] mask2_reg;

    always_comb begin
        lit_sum_next = '0;
        unl_sum_next = '0;
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (mask1_reg[i]) begin
                    lit_sum_next[c] = lit_sum_next[c] + SUM_W'(col1_reg[i][c*CH_W +: CH_W]);
                end else begin
                    unl_sum_next[c] = unl_sum_next[c] + SUM_W'(col1_reg[i][c*CH_W +: CH_W]);
                end
            end
        end
        lit_cnt_next = CNT_W'($countones(mask1_reg));
        unl_cnt_next = CNT_W'(NUM_SAMPLES) - lit_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            lit_sum_reg <= lit_sum_next;
            unl_sum_reg <= unl_sum_next;
            lit_cnt_reg <= lit_cnt_next;
            unl_cnt_reg <= unl_cnt_next;
            glyph2_reg  <= glyph_for(mask1_reg);
            mask2_reg   <= mask1_reg;
        end
    end

    // stages 3 and 4: divide by count via reciprocal, one lane per group
    sxt_group_avg u_fg_avg (
        .aclk  (aclk),
        .adv   (adv),
        .sums  (lit_sum_reg),
        .count (lit_cnt_reg),
        .color (m_fg_color)
    );

    sxt_group_avg u_bg_avg (
        .aclk  (aclk),
        .adv   (adv),
        .sums  (unl_sum_reg),
        .count (unl_cnt_reg),
        .color (m_bg_color)
    );

    // mask and glyph ride alongside the multiply and output stages
    logic [GLYPH_W-1:0]     glyph3_reg, glyph4_reg;
    logic [NUM_SAMPLES-1:0] mask3_reg, mask4_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            glyph3_reg <= glyph2_reg;
            mask3_reg  <= mask2_reg;
        end
        if (en4) begin
            glyph4_reg <= glyph3_reg;
            mask4_reg  <= mask3_reg;
        end
    end

    assign m_valid      = v4_reg;
    assign m_glyph_code = glyph4_reg;
    assign m_lit_mask   = mask4_reg;

    // input side only backs up when the whole pipeline is full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled full pipeline");

    // space exactly for the empty mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_lit_mask == MASK_EMPTY) == (m_glyph_code == CP_SPACE)))
        else $error("glyph and mask disagree on empty cell");

    // no lit samples gives a black foreground
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_lit_mask == MASK_EMPTY)) |-> (m_fg_color == '0))
        else $error("foreground not black for empty group");

    // all samples lit gives a black background
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_lit_mask == MASK_FULL)) |-> (m_bg_color == '0))
        else $error("background not black for empty group");

endmodule
